FILE: design/multilevel_feedback_queue_scheduler_assert.svh
// Assertion macros used by the scheduler controller RTL.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define MLFQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MLFQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mlfq_pkg.sv
// Types and constants of the feedback queue scheduler.
package mlfq_pkg;

  localparam int LV_OUT_W  = 3;
  localparam int AGE_FIRST = 2;
  localparam int SLICE_W   = 10;
  localparam logic [SLICE_W-1:0] SLICE_MAX = 10'd1023;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  localparam logic [1:0] REG_NUM_LEVELS = 2'd0;
  localparam logic [1:0] REG_BASE       = 2'd1;
  localparam logic [1:0] REG_AGING      = 2'd2;

  typedef struct packed {
    logic [15:0] pid;
    logic [15:0] left;
    logic [15:0] burst;
    logic [31:0] arrival;
    logic [31:0] ran_at;
  } entry_t;

  typedef struct packed {
    logic [2:0]  num_levels;
    logic [7:0]  base_quantum;
    logic [15:0] aging_threshold;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        busy_res;
    logic [15:0] run_pid;
    logic [2:0]  run_level;
    logic        done_res;
    logic [15:0] done_pid;
    logic [31:0] turnaround;
    logic [31:0] wait_ticks;
  } res_t;

endpackage

FILE: design/mlfq_if.sv
// Input and result channel interfaces.
interface mlfq_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] new_pid;
  logic [15:0] new_burst;
  modport source (output valid, mode, new_pid, new_burst, input ready);
  modport sink   (input valid, mode, new_pid, new_burst, output ready);
endinterface

interface mlfq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        busy_res;
  logic [15:0] run_pid;
  logic [2:0]  run_level;
  logic        done_res;
  logic [15:0] done_pid;
  logic [31:0] turnaround;
  logic [31:0] wait_ticks;
  modport source (output valid, status, busy_res, run_pid, run_level, done_res, done_pid,
                  turnaround, wait_ticks, input ready);
  modport sink   (input valid, status, busy_res, run_pid, run_level, done_res, done_pid,
                  turnaround, wait_ticks, output ready);
endinterface

FILE: design/mlfq_ram.sv
// Generic single-port-write, registered-read RAM.
module mlfq_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/mlfq_ctrl.sv
// Scheduler sequencer: level tables, entry RAM access, run and aging passes.
`include "multilevel_feedback_queue_scheduler_assert.svh"

module mlfq_ctrl #(
  parameter int MAX_LEVELS  = 5,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  mlfq_pkg::cfg_t cfg,
  mlfq_in_if.sink        in_ch,
  mlfq_out_if.source     out_ch
);
  localparam int ENTRIES = MAX_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int IDX_W   = $clog2(LEVEL_DEPTH);
  localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
  // wide enough to hold the first aging level even with two levels
  localparam int LV_W    = $clog2(MAX_LEVELS + 1);
  localparam int NL_W    = $clog2(MAX_LEVELS + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int E_W     = $bits(mlfq_pkg::entry_t);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_RUN     = 2'd1;
  localparam logic [1:0] S_AGE_CHK = 2'd2;
  localparam logic [1:0] S_AGE_WB  = 2'd3;

  logic [IDX_W-1:0] head [MAX_LEVELS];
  logic [CNT_W-1:0] cnt  [MAX_LEVELS];
  logic [31:0]      now;
  logic [mlfq_pkg::SLICE_W-1:0] slice;
  logic             active;
  logic [LV_W-1:0]  act_lv;
  logic [LV_W-1:0]  age_lv;
  logic [1:0]       state;
  logic             out_valid;
  mlfq_pkg::res_t   res;

  logic             ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  mlfq_pkg::entry_t ram_wdata, ram_rdata;
  logic [E_W-1:0]   rdata_bits;

  mlfq_ram #(.W(E_W), .D(ENTRIES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata_bits)
  );
  assign ram_rdata = mlfq_pkg::entry_t'(rdata_bits);

  function automatic logic [ADDR_W-1:0] slot(input logic [IDX_W-1:0] hd,
                                             input logic [LV_W-1:0] lv,
                                             input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] idx;
    sum = SUM_W'(hd) + SUM_W'(pos);
    idx = (sum >= SUM_W'(LEVEL_DEPTH)) ? sum - SUM_W'(LEVEL_DEPTH) : sum;
    return ADDR_W'(lv) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(idx);
  endfunction

  function automatic logic [IDX_W-1:0] inc_head(input logic [IDX_W-1:0] hd);
    return (hd == IDX_W'(LEVEL_DEPTH - 1)) ? '0 : hd + 1'b1;
  endfunction

  // levels in use, clamped
  logic [NL_W-1:0] nl;
  always_comb begin
    if (cfg.num_levels < 3'd2) begin
      nl = NL_W'(2);
    end else if (int'(cfg.num_levels) > MAX_LEVELS) begin
      nl = NL_W'(MAX_LEVELS);
    end else begin
      nl = NL_W'(cfg.num_levels);
    end
  end

  logic            pick_found;
  logic [LV_W-1:0] pick_lv;
  always_comb begin
    pick_found = 1'b0;
    pick_lv    = '0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (!pick_found && i < int'(nl) && cnt[i] != '0) begin
        pick_found = 1'b1;
        pick_lv    = LV_W'(i);
      end
    end
  end

  logic            in_xfer, out_xfer;
  logic            run_now;
  logic [LV_W-1:0] run_lv;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign run_now  = active || pick_found;
  assign run_lv   = active ? act_lv : pick_lv;

  // enqueue result
  mlfq_pkg::res_t enq_res;
  always_comb begin
    enq_res = '0;
    if (in_ch.new_burst == 16'd0) begin
      enq_res.status = mlfq_pkg::STATUS_ZERO;
    end else if (cnt[0] >= CNT_W'(LEVEL_DEPTH)) begin
      enq_res.status = mlfq_pkg::STATUS_FULL;
    end else begin
      enq_res.status = mlfq_pkg::STATUS_OK;
    end
  end

  // run-step values
  mlfq_pkg::entry_t run_e;
  mlfq_pkg::res_t   run_res;
  logic [mlfq_pkg::SLICE_W-1:0] slice_n;
  logic [LV_W-1:0]  nxt_lv;
  logic [10:0]      quantum;
  logic             run_done, run_demote, run_room;
  logic [31:0]      ta;
  always_comb begin
    run_e          = ram_rdata;
    run_e.left     = (ram_rdata.left != 16'd0) ? ram_rdata.left - 16'd1 : 16'd0;
    run_e.ran_at   = now;
    slice_n        = (slice < mlfq_pkg::SLICE_MAX) ? slice + 1'b1 : slice;
    nxt_lv         = act_lv + 1'b1;
    quantum        = 11'(cfg.base_quantum) * 11'(act_lv + 4'd1);
    run_done       = (run_e.left == 16'd0);
    run_demote     = !run_done && (int'(act_lv) < int'(nl) - 1) &&
                     (11'(slice_n) >= quantum);
    run_room       = cnt[nxt_lv] < CNT_W'(LEVEL_DEPTH);
    ta             = now - ram_rdata.arrival;
    run_res           = '0;
    run_res.busy_res  = 1'b1;
    run_res.run_pid   = ram_rdata.pid;
    run_res.run_level = mlfq_pkg::LV_OUT_W'(act_lv);
    if (run_done) begin
      run_res.done_res   = 1'b1;
      run_res.done_pid   = ram_rdata.pid;
      run_res.turnaround = ta;
      run_res.wait_ticks = ta - 32'(ram_rdata.burst);
    end
  end

  // aging values
  logic [LV_W-1:0] up_lv;
  logic            age_end, age_skip, age_hit;
  mlfq_pkg::entry_t age_e;
  always_comb begin
    up_lv    = age_lv - 1'b1;
    age_end  = (int'(age_lv) + 1 >= int'(nl));
    age_skip = (cnt[age_lv] == '0) || (active && act_lv == age_lv) ||
               (cnt[up_lv] >= CNT_W'(LEVEL_DEPTH));
    age_hit  = (now - ram_rdata.ran_at) >= 32'(cfg.aging_threshold);
    age_e        = ram_rdata;
    age_e.ran_at = now;
  end

  // RAM ports
  always_comb begin
    ram_raddr = slot(head[run_lv], run_lv, '0);
    if (state == S_AGE_CHK) begin
      ram_raddr = slot(head[age_lv], age_lv, '0);
    end
    ram_we    = 1'b0;
    ram_waddr = slot(head[0], '0, cnt[0]);
    ram_wdata = '{pid: in_ch.new_pid, left: in_ch.new_burst, burst: in_ch.new_burst,
                  arrival: now, ran_at: now};
    unique case (state)
      S_IDLE: begin
        ram_we = in_xfer && !in_ch.mode && in_ch.new_burst != 16'd0 &&
                 cnt[0] < CNT_W'(LEVEL_DEPTH);
      end
      S_RUN: begin
        ram_we    = 1'b1;
        ram_wdata = run_e;
        ram_waddr = (run_demote && run_room) ? slot(head[nxt_lv], nxt_lv, cnt[nxt_lv])
                                             : slot(head[act_lv], act_lv, '0);
      end
      S_AGE_WB: begin
        ram_we    = age_hit;
        ram_wdata = age_e;
        ram_waddr = slot(head[up_lv], up_lv, cnt[up_lv]);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head[i] <= '0;
        cnt[i]  <= '0;
      end
      now       <= '0;
      slice     <= '0;
      active    <= 1'b0;
      act_lv    <= '0;
      age_lv    <= '0;
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_xfer) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (!in_ch.mode) begin
              out_valid <= 1'b1;
              res       <= enq_res;
              if (enq_res.status == mlfq_pkg::STATUS_OK) begin
                cnt[0] <= cnt[0] + 1'b1;
              end
            end else begin
              res    <= '0;
              now    <= now + 32'd1;
              age_lv <= LV_W'(mlfq_pkg::AGE_FIRST);
              if (!active && pick_found) begin
                active <= 1'b1;
                act_lv <= pick_lv;
                slice  <= '0;
              end
              state <= run_now ? S_RUN : S_AGE_CHK;
            end
          end
        end
        S_RUN: begin
          res   <= run_res;
          slice <= slice_n;
          if (run_done) begin
            head[act_lv] <= inc_head(head[act_lv]);
            cnt[act_lv]  <= cnt[act_lv] - 1'b1;
            active       <= 1'b0;
          end else if (run_demote) begin
            if (run_room) begin
              cnt[nxt_lv]  <= cnt[nxt_lv] + 1'b1;
              head[act_lv] <= inc_head(head[act_lv]);
              cnt[act_lv]  <= cnt[act_lv] - 1'b1;
            end
            active <= 1'b0;
          end
          state <= S_AGE_CHK;
        end
        S_AGE_CHK: begin
          if (age_end) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else if (age_skip) begin
            age_lv <= age_lv + 1'b1;
          end else begin
            state <= S_AGE_WB;
          end
        end
        S_AGE_WB: begin
          if (age_hit) begin
            cnt[up_lv]   <= cnt[up_lv] + 1'b1;
            head[age_lv] <= inc_head(head[age_lv]);
            cnt[age_lv]  <= cnt[age_lv] - 1'b1;
          end
          age_lv <= age_lv + 1'b1;
          state  <= S_AGE_CHK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state == S_IDLE) && !out_valid;
  assign out_ch.valid      = out_valid;
  assign out_ch.status     = res.status;
  assign out_ch.busy_res   = res.busy_res;
  assign out_ch.run_pid    = res.run_pid;
  assign out_ch.run_level  = res.run_level;
  assign out_ch.done_res   = res.done_res;
  assign out_ch.done_pid   = res.done_pid;
  assign out_ch.turnaround = res.turnaround;
  assign out_ch.wait_ticks = res.wait_ticks;

  `MLFQ_ASSERT_IMP(a_cnt0_bound, 1'b1, cnt[0] <= CNT_W'(LEVEL_DEPTH), "level 0 overfilled")
  `MLFQ_ASSERT_IMP(a_active_nonempty, active && state == S_IDLE, cnt[act_lv] != '0,
                   "running job on empty level")
  `MLFQ_ASSERT_NXT(a_accept_progress, in_xfer, out_valid || state != S_IDLE,
                   "accepted item left no work")
endmodule

FILE: design/multilevel_feedback_queue_scheduler.sv
// Multilevel feedback queue scheduler, top level.
//
// in_ch carries one item per transfer: mode 0 enqueues a job (new_pid,
// new_burst) at the tail of level 0, mode 1 advances time by one tick.
// out_ch returns exactly one result per item, held in an output register
// until the receiver takes it; while that register is full in_ch.ready is low.
// Enqueue: result valid in the cycle after the input transfer.
// Tick: when a job runs, the running head is read from the entry RAM and
// updated in state S_RUN, then the aging pass visits levels 2 to num_levels-2,
// in S_AGE_CHK for every level and in S_AGE_WB as well for each examined head,
// and S_AGE_CHK registers the result at the end of the pass.
// The next item is taken the cycle after the result transfer.
// All job records live in one RAM of MAX_LEVELS*LEVEL_DEPTH entries; level
// heads and counts sit in flip-flops.
// Configuration: cfg_we, cfg_index, cfg_wdata, to be written by the user only
// while idle; the block does not enforce this. Reset (rst, synchronous) empties
// every level, clears time and the running job, and loads num_levels 3,
// base_quantum 10, aging_threshold 100. No RAM clearing pass is needed.
module multilevel_feedback_queue_scheduler #(
  parameter int MAX_LEVELS  = 5,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  mlfq_in_if.sink     in_ch,
  mlfq_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  mlfq_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{num_levels: 3'd3, base_quantum: 8'd10, aging_threshold: 16'd100};
    end else if (cfg_we) begin
      unique case (cfg_index)
        mlfq_pkg::REG_NUM_LEVELS: cfg.num_levels      <= cfg_wdata[2:0];
        mlfq_pkg::REG_BASE:       cfg.base_quantum    <= cfg_wdata[7:0];
        mlfq_pkg::REG_AGING:      cfg.aging_threshold <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  mlfq_ctrl #(.MAX_LEVELS(MAX_LEVELS), .LEVEL_DEPTH(LEVEL_DEPTH)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );
endmodule

FILE: dv/multilevel_feedback_queue_scheduler_tb.sv
// Self-checking testbench of the multilevel feedback queue scheduler.
module multilevel_feedback_queue_scheduler_tb;

  localparam int NLV = 5;
  localparam int DEPTH = 16;
  localparam int NENT = NLV * DEPTH;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  mlfq_in_if in_ch ();
  mlfq_out_if out_ch ();

  multilevel_feedback_queue_scheduler uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler shadow state
  logic [15:0] job_pid[NENT], job_left[NENT], job_burst[NENT];
  logic [31:0] job_arrival[NENT], job_ran_at[NENT];
  int unsigned lvl_head[NLV], lvl_count[NLV];
  logic [31:0] sched_now;
  int unsigned slice_ticks;
  bit running;
  int unsigned running_lvl;
  logic [2:0] sh_levels;
  logic [7:0] sh_base;
  logic [15:0] sh_aging;

  mlfq_pkg::res_t pending_res[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  function automatic int unsigned slot(int unsigned lv, int unsigned pos);
    return lv * DEPTH + (lvl_head[lv] + pos) % DEPTH;
  endfunction

  function automatic void pop_head(int unsigned lv);
    lvl_head[lv] = (lvl_head[lv] + 1) % DEPTH;
    lvl_count[lv]--;
  endfunction

  function automatic void shift_head(int unsigned src, int unsigned dst);
    int unsigned a, b;
    a = slot(src, 0);
    b = slot(dst, lvl_count[dst]);
    job_pid[b] = job_pid[a];
    job_left[b] = job_left[a];
    job_burst[b] = job_burst[a];
    job_arrival[b] = job_arrival[a];
    job_ran_at[b] = job_ran_at[a];
    lvl_count[dst]++;
    pop_head(src);
  endfunction

  function automatic mlfq_pkg::res_t schedule_item(bit m, logic [15:0] pid,
                                                   logic [15:0] burst);
    mlfq_pkg::res_t r;
    int unsigned nl, lv, i, s, quantum;
    logic [31:0] ta;
    r = '0;
    if (sh_levels < 3'd2) nl = 2;
    else if (int'(sh_levels) > NLV) nl = NLV;
    else nl = int'(sh_levels);
    if (!m) begin
      if (burst == 16'd0) r.status = mlfq_pkg::STATUS_ZERO;
      else if (lvl_count[0] >= DEPTH) r.status = mlfq_pkg::STATUS_FULL;
      else begin
        s = slot(0, lvl_count[0]);
        job_pid[s] = pid;
        job_left[s] = burst;
        job_burst[s] = burst;
        job_arrival[s] = sched_now;
        job_ran_at[s] = sched_now;
        lvl_count[0]++;
      end
      return r;
    end
    if (!running) begin
      for (i = 0; i < nl; i++) begin
        if (lvl_count[i] > 0) begin
          running = 1'b1;
          running_lvl = i;
          slice_ticks = 0;
          break;
        end
      end
    end
    sched_now = sched_now + 32'd1;
    if (running) begin
      lv = running_lvl;
      s = slot(lv, 0);
      r.busy_res = 1'b1;
      r.run_pid = job_pid[s];
      r.run_level = lv[2:0];
      if (job_left[s] > 16'd0) job_left[s]--;
      if (slice_ticks < mlfq_pkg::SLICE_MAX) slice_ticks++;
      job_ran_at[s] = sched_now;
      if (job_left[s] == 16'd0) begin
        ta = sched_now - job_arrival[s];
        r.done_res = 1'b1;
        r.done_pid = job_pid[s];
        r.turnaround = ta;
        r.wait_ticks = ta - {16'd0, job_burst[s]};
        pop_head(lv);
        running = 1'b0;
      end else if (lv < nl - 1) begin
        quantum = int'(sh_base) * (lv + 1);
        if (slice_ticks >= quantum) begin
          if (lvl_count[lv + 1] < DEPTH) shift_head(lv, lv + 1);
          running = 1'b0;
        end
      end
    end
    for (i = mlfq_pkg::AGE_FIRST; i + 1 < nl; i++) begin
      if (lvl_count[i] == 0) continue;
      if (running && running_lvl == i) continue;
      if (lvl_count[i - 1] >= DEPTH) continue;
      s = slot(i, 0);
      if ((sched_now - job_ran_at[s]) >= {16'd0, sh_aging}) begin
        job_ran_at[s] = sched_now;
        shift_head(i, i - 1);
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // receiver: checks results and stalls
  always @(posedge clk) begin
    mlfq_pkg::res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_res.size() == 0) report("unexpected result", 32'd0, 32'd0);
      else begin
        want = pending_res.pop_front();
        if (out_ch.status !== want.status)
          report("status", 32'(out_ch.status), 32'(want.status));
        if (out_ch.busy_res !== want.busy_res)
          report("busy", 32'(out_ch.busy_res), 32'(want.busy_res));
        if (out_ch.run_pid !== want.run_pid)
          report("run_pid", 32'(out_ch.run_pid), 32'(want.run_pid));
        if (out_ch.run_level !== want.run_level)
          report("run_level", 32'(out_ch.run_level), 32'(want.run_level));
        if (out_ch.done_res !== want.done_res)
          report("done", 32'(out_ch.done_res), 32'(want.done_res));
        if (out_ch.done_pid !== want.done_pid)
          report("done_pid", 32'(out_ch.done_pid), 32'(want.done_pid));
        if (out_ch.turnaround !== want.turnaround)
          report("turnaround", out_ch.turnaround, want.turnaround);
        if (out_ch.wait_ticks !== want.wait_ticks)
          report("wait_ticks", out_ch.wait_ticks, want.wait_ticks);
      end
    end
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_item(bit m, logic [15:0] pid, logic [15:0] burst,
                           bit typed, mlfq_pkg::res_t typed_res);
    mlfq_pkg::res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.new_pid <= pid;
    in_ch.new_burst <= burst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = schedule_item(m, pid, burst);
    pending_res.insert(pending_res.size(), typed ? typed_res : r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mlfq_pkg::REG_NUM_LEVELS: sh_levels = val[2:0];
      mlfq_pkg::REG_BASE:       sh_base = val[7:0];
      mlfq_pkg::REG_AGING:      sh_aging = val;
      default: ;
    endcase
  endtask

  typedef struct {
    bit             m;
    logic [15:0]    pid;
    logic [15:0]    burst;
    bit             typed;
    mlfq_pkg::res_t res;
  } stim_row_t;

  stim_row_t dir_rows[$];

  function automatic void add_row(bit m, logic [15:0] pid, logic [15:0] burst,
                                  bit typed, mlfq_pkg::res_t res);
    stim_row_t row;
    row.m = m; row.pid = pid; row.burst = burst; row.typed = typed; row.res = res;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // phase settings: levels, base, aging, sender idle, receiver stall, enqueue share
  int ph_levels[7] = '{3, 5, 4, 2, 7, 1, 0};
  int ph_base[7]   = '{10, 1, 0, 255, 2, 3, 1};
  int ph_aging[7]  = '{100, 3, 0, 65535, 1, 5, 2};
  int ph_idle[7]   = '{0, 45, 0, 34, 0, 34, 45};
  int ph_stall[7]  = '{0, 0, 45, 34, 0, 34, 0};
  int ph_enq[7]    = '{40, 35, 40, 30, 80, 35, 35};

  initial begin
    mlfq_pkg::res_t z, done1;
    logic [15:0] b;
    sched_now = '0; slice_ticks = 0; running = 1'b0; running_lvl = 0;
    sh_levels = 3'd3; sh_base = 8'd10; sh_aging = 16'd100;
    for (int i = 0; i < NLV; i++) begin
      lvl_head[i] = 0;
      lvl_count[i] = 0;
    end
    for (int i = 0; i < NENT; i++) begin
      job_pid[i] = '0; job_left[i] = '0; job_burst[i] = '0;
      job_arrival[i] = '0; job_ran_at[i] = '0;
    end
    in_ch.valid <= 1'b0;
    in_ch.mode <= 1'b0;
    in_ch.new_pid <= '0;
    in_ch.new_burst <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    z = '0;
    done1 = '0;
    done1.busy_res = 1'b1; done1.run_pid = 16'hffff; done1.done_res = 1'b1;
    done1.done_pid = 16'hffff; done1.turnaround = 32'd1;
    add_row(1'b1, 16'h0, 16'h0, 1'b1, z);           // idle tick after reset
    z.status = mlfq_pkg::STATUS_ZERO;
    add_row(1'b0, 16'h0001, 16'h0, 1'b1, z);        // zero burst dropped
    z.status = mlfq_pkg::STATUS_OK;
    add_row(1'b0, 16'hffff, 16'h0001, 1'b1, z);
    add_row(1'b1, 16'h0, 16'h0, 1'b1, done1);
    add_row(1'b0, 16'h0000, 16'hffff, 1'b1, z);
    add_row(1'b0, 16'h1234, 16'h0003, 1'b1, z);
    for (int i = 0; i < 16; i++) add_row(1'b1, 16'hffff, 16'hffff, 1'b0, z);
    foreach (dir_rows[i])
      push_item(dir_rows[i].m, dir_rows[i].pid, dir_rows[i].burst,
                dir_rows[i].typed, dir_rows[i].res);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(mlfq_pkg::REG_NUM_LEVELS, ph_levels[ph][15:0]);
      write_reg(mlfq_pkg::REG_BASE, ph_base[ph][15:0]);
      write_reg(mlfq_pkg::REG_AGING, ph_aging[ph][15:0]);
      send_idle_pct = ph_idle[ph];
      recv_stall_pct = ph_stall[ph];
      if (ph == 4) hold_req = 1'b1;   // long receiver hold-off while flooding
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(99) < ph_enq[ph]) begin
          case ($urandom_range(49))
            0: b = 16'h0;
            1: b = 16'($urandom);
            default: b = 16'($urandom_range(20, 1));
          endcase
          push_item(1'b0, 16'($urandom), b, 1'b0, z);
        end else begin
          push_item(1'b1, 16'($urandom), 16'($urandom), 1'b0, z);
        end
        if (ph == 0 && n == 50) begin
          send_idle_pct = 45;
          recv_stall_pct = 45;
        end
      end
      drain();
    end

    if (errors == 0 && pending_res.size() == 0)
      $display("multilevel_feedback_queue_scheduler_tb: PASS");
    else
      $display("multilevel_feedback_queue_scheduler_tb: FAIL");
    $finish;
  end

  initial begin
    #3000000;
    $display("multilevel_feedback_queue_scheduler_tb: FAIL");
    $finish;
  end

endmodule
